### hw/rtl/sidt_pkg.sv
// Shared types and constants for the sorted id lower-bound search block.
package sidt_pkg;

  localparam int IdW    = 32;
  localparam int IndexW = 10;
  localparam int CountW = 11;
  localparam int PosW   = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } srch_state_t;

  typedef struct packed {
    logic [IdW-1:0]    key;
    logic [CountW-1:0] count;
  } srch_req_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            found;
  } srch_res_t;

endpackage

### hw/rtl/sidt_mem.sv
// Id table: single-port-write, single-port-read synchronous memory, registered read data.
module sidt_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [sidt_pkg::IdW-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [sidt_pkg::IdW-1:0] rd_data
);
  import sidt_pkg::*;

  logic [IdW-1:0] mem [DEPTH];
  logic [IdW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/sidt_search.sv
// Binary search sequencer: one table read and one compare per probe.
module sidt_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  sidt_pkg::srch_req_t      req,
  output logic                     idle,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic [sidt_pkg::IdW-1:0] rd_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output sidt_pkg::srch_res_t      res
);
  import sidt_pkg::*;

  localparam int XW = (CW > CountW) ? CW : CountW;
  localparam logic [XW-1:0] DepthX = XW'(TABLE_DEPTH);

  srch_state_t    state_r, state_nxt;
  logic [IdW-1:0] key_r, key_nxt;
  logic [CW-1:0]  base_r, base_nxt;
  logic [CW-1:0]  span_r, span_nxt;
  logic           hit_r, hit_nxt;
  logic [CW-1:0]  probe;
  logic [CW-1:0]  span_cmp;
  logic [XW-1:0]  cnt_ext;
  logic [CW-1:0]  cnt_sat;

  assign cnt_ext = XW'(req.count);
  assign cnt_sat = (cnt_ext > DepthX) ? CW'(DepthX) : CW'(cnt_ext);
  assign probe   = base_r + (span_r >> 1);

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    base_nxt  = base_r;
    span_nxt  = span_r;
    hit_nxt   = hit_r;
    span_cmp  = span_r >> 1;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = req.key;
          base_nxt  = '0;
          span_nxt  = cnt_sat;
          hit_nxt   = 1'b0;
          state_nxt = (cnt_sat == '0) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (key_r == rd_data) begin
          base_nxt  = probe;
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          // drop the probed entry and the half that cannot hold the key
          if (key_r > rd_data) begin
            base_nxt = probe + CW'(1);
            span_cmp = (span_r - CW'(1)) >> 1;
          end
          span_nxt  = span_cmp;
          state_nxt = (span_cmp == '0) ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    base_r <= base_nxt;
    span_r <= span_nxt;
    hit_r  <= hit_nxt;
  end

  assign idle         = (state_r == S_IDLE);
  assign rd_en        = (state_r == S_READ);
  assign rd_addr      = AW'(probe);
  assign res_valid    = (state_r == S_DONE);
  assign res.position = PosW'(base_r);
  assign res.found    = hit_r;

endmodule

### hw/rtl/sorted_id_lower_bound_search_top.sv
// Top level of the sorted id table with lower-bound binary search.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  in_     | in  | entry_index[9:0] entry_id[41:10] entry_count[52:42] | cmd
//  out_    | out | position[10:0]                                  | found
//
// A write item produces no result.
// A search does a memory read, then a compare, for each probe, and makes at most
// clog2(count+1) probes.
// The table memory's single read port sets the probe rate.
// Reset clears control only; the table holds garbage until written.
// The result sits in an output register, so the search goes idle while it stalls;
// a later result waits in done; a write may still follow only once the search is idle.
module sorted_id_lower_bound_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // entry_index[9:0], entry_id[41:10], entry_count[52:42]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // position[10:0]
  output logic [0:0]  out_tuser   // found[0]
);
  import sidt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic              in_xfer;
  logic [IndexW-1:0] in_index;
  logic [IdW-1:0]    in_id;
  logic [CountW-1:0] in_count;
  logic              wr_en;
  logic              srch_start;
  logic              srch_idle;
  srch_req_t         req;
  srch_res_t         res;
  logic              res_valid;
  logic              res_ready;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [IdW-1:0]    rd_data;
  logic              out_valid_r;
  srch_res_t         out_res_r;

  assign in_index = in_tdata[IndexW-1:0];
  assign in_id    = in_tdata[IndexW+IdW-1:IndexW];
  assign in_count = in_tdata[IndexW+IdW+CountW-1:IndexW+IdW];

  assign in_tready  = srch_idle;
  assign in_xfer    = in_tvalid && in_tready;
  assign srch_start = in_xfer && (in_tuser[0] == CMD_SEARCH);
  // ignore slots past the end of the table
  assign wr_en      = in_xfer && (in_tuser[0] == CMD_WRITE) &&
                      (32'(in_index) < 32'(TABLE_DEPTH));

  assign req.key   = in_id;
  assign req.count = in_count;

  sidt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_index)),
    .wr_data (in_id),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sidt_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (srch_start),
    .req       (req),
    .idle      (srch_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_res_r.position);
  assign out_tuser  = out_res_r.found;

endmodule

### hw/rtl/sidt_checker.sv
// Port-level checker for the sorted id search top, with its bind.
module sidt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import sidt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one search at a time
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == CMD_SEARCH) |=> !in_tready)
    else $error("input taken while a search runs");

  // a write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == CMD_WRITE) && !out_tvalid |=> !out_tvalid)
    else $error("result after a write");

  // a new result follows a busy search
  a_res_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without a running search");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:PosW] == '0))
    else $error("nonzero padding in result");

endmodule

bind sorted_id_lower_bound_search_top sidt_checker u_sidt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### test/tb_top.sv
// Self-checking testbench for the sorted id table with lower-bound binary search.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sidt_pkg::*;

  localparam int          TABLE_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          RANDOM_ITEMS = 260;
  localparam int          DRAIN_CYCLES = 40;
  // Slots 0 .. FILL_COUNT-1 get written; the top one holds all ones.
  localparam int unsigned FILL_COUNT = 513;

  // Tracks the table contents and the search answers still owed by the block.
  class id_table_tracker;
    bit [IdW-1:0] ids [TABLE_DEPTH];
    srch_res_t    pending_results [$];
    int unsigned  errors;
    int unsigned  results_seen;

    task report(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Halving search; stops at the first probe equal to the key.
    function srch_res_t lower_bound(bit [IdW-1:0] key, int unsigned count);
      int unsigned base;
      int unsigned span;
      int unsigned probe;
      bit          hit;
      srch_res_t   res;
      base = 0;
      hit  = 1'b0;
      if (count > TABLE_DEPTH) count = TABLE_DEPTH;
      span = count;
      while (span != 0) begin
        probe = base + (span >> 1);
        if (key == ids[probe]) begin
          base = probe;
          hit  = 1'b1;
          break;
        end
        if (key > ids[probe]) begin
          base = probe + 1;
          span--;
        end
        span = span >> 1;
      end
      res.position = base[PosW-1:0];
      res.found    = hit;
      return res;
    endfunction

    function void note_transfer(logic cmd, logic [IndexW-1:0] idx, logic [IdW-1:0] id,
                                logic [CountW-1:0] cnt);
      if (cmd == CMD_WRITE) begin
        if (idx < TABLE_DEPTH) ids[idx] = id;
      end else begin
        pending_results.push_back(lower_bound(id, cnt));
      end
    endfunction

    task check_result(logic [PosW-1:0] pos, logic found);
      srch_res_t exp_res;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result position=%0d found=%0b", pos, found));
      end else begin
        exp_res = pending_results.pop_front();
        if (pos !== exp_res.position)
          report($sformatf("position %0d, expected %0d", pos, exp_res.position));
        if (found !== exp_res.found)
          report($sformatf("found %0b, expected %0b (position %0d)",
                           found, exp_res.found, exp_res.position));
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  id_table_tracker sb = new();
  int unsigned     items_sent = 0;
  int unsigned     cycles = 0;

  sorted_id_lower_bound_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watch both channels at the edge where a transfer happens.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_transfer(in_tuser[0], in_tdata[9:0], in_tdata[41:10], in_tdata[52:42]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[PosW-1:0], out_tuser[0]);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_id_lower_bound_search_top: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, one stretch with no stalls.
  initial begin
    int  hold;
    bit  pressure_done;
    pressure_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!pressure_done && sb.results_seen >= 20) begin
        out_tready    <= 1'b0;
        pressure_done = 1'b1;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
      end
      if (sb.results_seen >= 30 && sb.results_seen < 60)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(0, 99) >= 32);
    end
  end

  // Offer one item and hold it until the transfer; tvalid stays high into the next call.
  task automatic send_item(logic cmd, logic [IndexW-1:0] idx, logic [IdW-1:0] id,
                           logic [CountW-1:0] cnt);
    bit gaps_on;
    gaps_on = !(items_sent >= 200 && items_sent < 400);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, cnt, id, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [IdW-1:0] pick_key(int unsigned count);
    int unsigned span;
    int unsigned r;
    logic [IdW-1:0] k;
    span = (count > FILL_COUNT) ? FILL_COUNT : count;
    r = $urandom_range(0, 99);
    if (span != 0 && r < 50) begin
      k = sb.ids[$urandom_range(0, span - 1)];
    end else if (span != 0 && r < 70) begin
      k = sb.ids[$urandom_range(0, span - 1)];
      k = $urandom_range(0, 1) ? k + 1 : k - 1;
    end else if (r < 80) begin
      k = $urandom_range(0, 1) ? '0 : '1;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  initial begin
    int unsigned    i;
    int unsigned    j;
    int unsigned    n;
    int unsigned    n_search;
    int unsigned    cnt;
    int unsigned    r;
    int unsigned    stop_at;
    bit             scrambled;
    longint unsigned acc;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Zero count makes no probe, so it is safe before anything is written.
    send_item(CMD_SEARCH, 10'h3FF, 32'h0000_0000, 11'd0);
    send_item(CMD_SEARCH, 10'h000, 32'hFFFF_FFFF, 11'd0);

    // Fill a sorted prefix; the all-ones top slot is the first probe of a
    // full-depth search, so every key either hits it or turns into the prefix.
    for (i = 0; i < FILL_COUNT; i++) begin
      if (i == 0)
        acc = 0;
      else if (i == FILL_COUNT - 1)
        acc = 64'hFFFF_FFFF;
      else
        acc = longint'(i) * 4000000;
      send_item(CMD_WRITE, i[IndexW-1:0], acc[31:0], 11'h7FF);
    end

    send_item(CMD_SEARCH, 10'd0, 32'h0000_0000, 11'd1024);
    send_item(CMD_SEARCH, 10'd0, 32'hFFFF_FFFF, 11'd1024);
    send_item(CMD_SEARCH, 10'd0, 32'hFFFF_FFFF, 11'd2047);  // count saturates
    send_item(CMD_SEARCH, 10'd0, 32'd4000001, 11'd1024);
    send_item(CMD_SEARCH, 10'd0, 32'd12345, 11'd1);
    send_item(CMD_SEARCH, 10'd0, 32'd2000000000, 11'd1024);
    send_item(CMD_SEARCH, 10'd0, 32'd4088000001, 11'd1500);

    // Duplicate ids: the first equal probe wins.
    for (i = 0; i < 8; i++)
      send_item(CMD_WRITE, i[IndexW-1:0], (i == 7) ? 32'd9 : 32'd5, 11'd0);
    send_item(CMD_SEARCH, 10'd0, 32'd5, 11'd8);
    send_item(CMD_SEARCH, 10'd0, 32'd9, 11'd8);
    send_item(CMD_SEARCH, 10'd0, 32'd10, 11'd8);

    // Unsorted prefix: the probe path still runs on whatever is stored.
    send_item(CMD_WRITE, 10'd0, 32'd100, 11'd0);
    send_item(CMD_WRITE, 10'd1, 32'd1, 11'd0);
    send_item(CMD_WRITE, 10'd2, 32'd50, 11'd0);
    send_item(CMD_WRITE, 10'd3, 32'd2, 11'd0);
    send_item(CMD_SEARCH, 10'd0, 32'd50, 11'd4);
    send_item(CMD_SEARCH, 10'd0, 32'd3, 11'd4);

    // Random runs: rebuild a prefix, sorted unless scrambled, then search it.
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 29);
      n = (r == 0) ? $urandom_range(64, 256) : (r < 3) ? 0 : $urandom_range(1, 40);
      scrambled = ($urandom_range(0, 9) == 0);
      acc = $urandom_range(0, 3) == 0 ? longint'($urandom) : $urandom_range(0, 1000);
      for (i = 0; i < n; i++) begin
        if (scrambled) begin
          acc = $urandom;
        end else if (i != 0) begin
          r = $urandom_range(0, 9);
          if (r >= 1 && r <= 3) acc = acc + 1;
          else if (r > 3) acc = acc + $urandom_range(1, 1 << 24);
          if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        end
        send_item(CMD_WRITE, i[IndexW-1:0], acc[31:0], 11'($urandom_range(0, 2047)));
      end
      n_search = $urandom_range(4, 16);
      for (j = 0; j < n_search; j++) begin
        // counts between the filled prefix and the depth would probe unwritten slots
        r = $urandom_range(0, 99);
        if (r < 70 && n != 0) cnt = n;
        else if (r < 85) cnt = $urandom_range(0, FILL_COUNT);
        else if (r < 95) cnt = $urandom_range(TABLE_DEPTH, 2047);
        else cnt = 0;
        send_item(CMD_SEARCH, 10'($urandom_range(0, 1023)), pick_key(cnt),
                  cnt[CountW-1:0]);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("sorted_id_lower_bound_search_top: match");
    else
      $display("sorted_id_lower_bound_search_top: mismatch");
    $finish;
  end

endmodule

### sorted_id_lower_bound_search_top.f
hw/rtl/sidt_pkg.sv
hw/rtl/sidt_mem.sv
hw/rtl/sidt_search.sv
hw/rtl/sorted_id_lower_bound_search_top.sv
hw/rtl/sidt_checker.sv
test/tb_top.sv
